/* design/vpbs_pkg.sv */
// ----------------------------------------------------------------------------
// vpbs_pkg: shared definitions for the particle box step block
// Field widths, register map codes, fixed-point constants and saturation.
// ----------------------------------------------------------------------------
package vpbs_pkg;

  // Field widths
  localparam int unsigned PosW    = 32;
  localparam int unsigned TickW   = 32;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned InDataW = 160;
  localparam int unsigned OutDataW = 120;
  localparam int unsigned AddrW   = 5;

  // Register indexes, taken from paddr[4:2]
  localparam logic [2:0] RegRadius    = 3'd0;
  localparam logic [2:0] RegFriction  = 3'd1;
  localparam logic [2:0] RegBounce    = 3'd2;
  localparam logic [2:0] RegGravity   = 3'd3;
  localparam logic [2:0] RegBoxWidth  = 3'd4;
  localparam logic [2:0] RegBoxHeight = 3'd5;

  // Register reset values
  localparam logic [27:0] RadiusRst    = 28'd10485760;
  localparam logic [15:0] FrictionRst  = 16'd32768;
  localparam logic [15:0] BounceRst    = 16'd27853;
  localparam logic [19:0] GravityRst   = 20'd105;
  localparam logic [30:0] BoxWidthRst  = 31'd524288000;
  localparam logic [30:0] BoxHeightRst = 31'd524288000;

  // 500.0 in Q11.20, the horizontal color center
  localparam logic signed [34:0] CenterX = 35'sd524288000;
  // floor(n/5) = (n * DivFiveRecip) >> 18 for all n below 2^18
  localparam logic [15:0] DivFiveRecip = 16'd52429;
  // floor(t/50) = (t * DivFiftyRecip) >> 36 for any 32-bit t
  localparam logic [32:0] DivFiftyRecip = 33'h0_51EB_851F;

  // Wall contact flags gathered during the move
  typedef struct packed {
    logic hit_x;
    logic hit_y;
    logic on_floor;
  } hit_t;

  // Clamp a 35-bit signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v[34:31] == {4{v[31]}}) begin
      r = v[31:0];
    end else if (v[34]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

/* design/verlet_particle_box_step.sv */
// ----------------------------------------------------------------------------
// verlet_particle_box_step: one Verlet step of a particle in a box
// Q11.20 position update with wall clamp, Q1.15 bounce and floor friction.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake               | content
//  ---------+-----+-------------------------+-----------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | load or step request
//  m_axis   | out | m_axis_tvalid/tready    | position, colors, tick count
//  apb      | in  | psel/penable, pready=1  | six config registers, 4-byte spaced
//
//  A step item runs through accept, velocity, move and clamp, then one
//  pass each of the shared 33x33 multiplier for x bounce, y bounce,
//  friction (only when the particle lands on the floor) and the tick color.
//  A load item runs through state capture, then the color pass.
//  s_axis_tready is high only while the sequencer is idle; a finished result
//  sits in the output register and the sequencer holds in its last step
//  until that register is free. Reset clears the particle state and
//  restores the register defaults; there is no clearing pass.
//
module verlet_particle_box_step (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // s_axis: tdata = load_x, load_y, load_prev_x, load_prev_y, load_ticks
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [vpbs_pkg::InDataW-1:0]   s_axis_tdata,
  // s_axis: tuser = req_type
  input  logic                           s_axis_tuser,
  // m_axis: tdata = pos_x, pos_y, color_red, color_green, color_blue,
  //         tick_count
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [vpbs_pkg::OutDataW-1:0]  m_axis_tdata,
  // apb config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vpbs_pkg::AddrW-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import vpbs_pkg::*;

  // Sequencer states
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SVel  = 3'd1;
  localparam logic [2:0] SMove = 3'd2;
  localparam logic [2:0] SBx   = 3'd3;
  localparam logic [2:0] SBy   = 3'd4;
  localparam logic [2:0] SFric = 3'd5;
  localparam logic [2:0] SBlue = 3'd6;

  logic [2:0] state_q, state_d;

  // Config registers
  logic [27:0] radius_q;
  logic [15:0] friction_q, bounce_q;
  logic [19:0] gravity_q;
  logic [30:0] box_width_q, box_height_q;

  // Particle state
  logic signed [31:0] cur_x_q, cur_y_q, old_x_q, old_y_q;
  logic [TickW-1:0]   ticks_q;
  logic               is_load_q;

  // Working registers
  logic signed [31:0] vx_q, vy_q, nx_q, ny_q, ox_q, oy_q;
  logic signed [32:0] diff_q;
  hit_t               hit_q;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  // ---------------------------------------------------------------- config
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q     <= RadiusRst;
      friction_q   <= FrictionRst;
      bounce_q     <= BounceRst;
      gravity_q    <= GravityRst;
      box_width_q  <= BoxWidthRst;
      box_height_q <= BoxHeightRst;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        RegRadius:    radius_q     <= pwdata[27:0];
        RegFriction:  friction_q   <= pwdata[15:0];
        RegBounce:    bounce_q     <= pwdata[15:0];
        RegGravity:   gravity_q    <= pwdata[19:0];
        RegBoxWidth:  box_width_q  <= pwdata[30:0];
        RegBoxHeight: box_height_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[4:2])
      RegRadius:    prdata = {4'd0, radius_q};
      RegFriction:  prdata = {16'd0, friction_q};
      RegBounce:    prdata = {16'd0, bounce_q};
      RegGravity:   prdata = {12'd0, gravity_q};
      RegBoxWidth:  prdata = {1'b0, box_width_q};
      RegBoxHeight: prdata = {1'b0, box_height_q};
      default:      prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  logic in_acc, out_free, issue;
  assign s_axis_tready = (state_q == SIdle);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign issue         = (state_q == SBlue) && out_free;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------- shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [33:0] mq;

  // Pick operands for the current step
  always_comb begin
    case (state_q)
      SBx:     begin mul_a = {vx_q[31], vx_q};  mul_b = {17'd0, bounce_q};   end
      SBy:     begin mul_a = {vy_q[31], vy_q};  mul_b = {17'd0, bounce_q};   end
      SFric:   begin mul_a = diff_q;            mul_b = {17'd0, friction_q}; end
      SBlue:   begin mul_a = {1'b0, ticks_q};   mul_b = DivFiftyRecip;       end
      default: begin mul_a = 33'sd0;            mul_b = 33'sd0;              end
    endcase
  end

  assign prod = mul_a * mul_b;
  // Q1.15 product, floor by arithmetic shift
  assign mq   = prod[48:15];

  // ---------------------------------------------------------------- velocity
  logic signed [31:0] vx_d, vy_raw, vy_d;
  assign vx_d   = sat35({{3{cur_x_q[31]}}, cur_x_q} - {{3{old_x_q[31]}}, old_x_q});
  assign vy_raw = sat35({{3{cur_y_q[31]}}, cur_y_q} - {{3{old_y_q[31]}}, old_y_q});
  assign vy_d   = sat35({{3{vy_raw[31]}}, vy_raw} + {15'd0, gravity_q});

  // ---------------------------------------------------------------- move and clamp
  logic signed [31:0] nx_s, ny_s;
  logic signed [34:0] r35, lim_x, lim_y, nx1, ny1, nx2, ny2;
  logic               lo_x, hi_x, lo_y, hi_y;
  hit_t               hit_d;

  assign nx_s  = sat35({{3{cur_x_q[31]}}, cur_x_q} + {{3{vx_q[31]}}, vx_q});
  assign ny_s  = sat35({{3{cur_y_q[31]}}, cur_y_q} + {{3{vy_q[31]}}, vy_q});
  assign r35   = {7'd0, radius_q};
  assign lim_x = {4'd0, box_width_q} - {6'd0, radius_q, 1'b0};
  assign lim_y = {4'd0, box_height_q} - {6'd0, radius_q, 1'b0};

  // Left wall first, the right wall overrides when the walls cross
  always_comb begin
    lo_x = $signed({{3{nx_s[31]}}, nx_s}) < r35;
    nx1  = lo_x ? r35 : {{3{nx_s[31]}}, nx_s};
    hi_x = nx1 > lim_x;
    nx2  = hi_x ? lim_x : nx1;
    lo_y = $signed({{3{ny_s[31]}}, ny_s}) < r35;
    ny1  = lo_y ? r35 : {{3{ny_s[31]}}, ny_s};
    hi_y = ny1 > lim_y;
    ny2  = hi_y ? lim_y : ny1;
    hit_d.hit_x    = lo_x | hi_x;
    hit_d.hit_y    = lo_y | hi_y;
    hit_d.on_floor = hi_y;
  end

  // ---------------------------------------------------------------- reflect
  logic signed [31:0] bx_d, by_d, fr_d;
  logic signed [32:0] diff_d;
  assign bx_d   = sat35({{3{nx_q[31]}}, nx_q} + {mq[33], mq});
  assign by_d   = sat35({{3{ny_q[31]}}, ny_q} + {mq[33], mq});
  assign fr_d   = sat35({{3{nx_q[31]}}, nx_q} - {mq[33], mq});
  assign diff_d = {nx_q[31], nx_q} - {ox_q[31], ox_q};

  // ---------------------------------------------------------------- colors
  logic signed [31:0] pos_x, pos_y;
  logic [TickW-1:0]   tick_after;
  logic signed [34:0] dxc, adx;
  logic [31:0]        ady;
  logic [12:0]        n_r;
  logic [11:0]        n_g;
  logic [28:0]        q_r;
  logic [27:0]        q_g;
  logic [ColorW-1:0]  red, green, green_mag, blue;

  assign pos_x      = is_load_q ? cur_x_q : nx_q;
  assign pos_y      = is_load_q ? cur_y_q : ny_q;
  assign tick_after = is_load_q ? ticks_q : ticks_q + 32'd1;

  // Integer part of the distance from the center, divided by five
  assign dxc   = {{3{pos_x[31]}}, pos_x} - CenterX;
  assign adx   = dxc[34] ? -dxc : dxc;
  assign n_r   = adx[32:20];
  assign q_r   = {16'd0, n_r} * {13'd0, DivFiveRecip};
  assign red   = q_r[25:18];

  // Height over five, truncated toward zero
  assign ady       = pos_y[31] ? 32'd0 - pos_y : pos_y;
  assign n_g       = ady[31:20];
  assign q_g       = {16'd0, n_g} * {12'd0, DivFiveRecip};
  assign green_mag = q_g[25:18];
  assign green     = pos_y[31] ? 8'd0 - green_mag : green_mag;

  assign blue = prod[43:36];

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:   if (in_acc) state_d = s_axis_tuser ? SBlue : SVel;
      SVel:    state_d = SMove;
      SMove:   state_d = SBx;
      SBx:     state_d = SBy;
      SBy:     state_d = hit_q.on_floor ? SFric : SBlue;
      SFric:   state_d = SBlue;
      SBlue:   if (out_free) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
      is_load_q   <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      old_x_q     <= '0;
      old_y_q     <= '0;
      ticks_q     <= '0;
    end else begin
      state_q <= state_d;
      // Raise the result on issue, drop it once taken
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      // Capture a load directly into the particle state
      if (in_acc) begin
        is_load_q <= s_axis_tuser;
        if (s_axis_tuser) begin
          cur_x_q <= s_axis_tdata[31:0];
          cur_y_q <= s_axis_tdata[63:32];
          old_x_q <= s_axis_tdata[95:64];
          old_y_q <= s_axis_tdata[127:96];
          ticks_q <= s_axis_tdata[159:128];
        end
      end
      // Commit a finished step
      if (issue && !is_load_q) begin
        cur_x_q <= nx_q;
        cur_y_q <= ny_q;
        old_x_q <= ox_q;
        old_y_q <= oy_q;
        ticks_q <= tick_after;
      end
    end
  end

  // Working registers advance with the sequencer
  always_ff @(posedge clk_i) begin
    case (state_q)
      SVel: begin
        vx_q <= vx_d;
        vy_q <= vy_d;
      end
      SMove: begin
        nx_q  <= nx2[31:0];
        ny_q  <= ny2[31:0];
        hit_q <= hit_d;
      end
      SBx: ox_q <= hit_q.hit_x ? bx_d : cur_x_q;
      SBy: begin
        oy_q   <= hit_q.hit_y ? by_d : cur_y_q;
        diff_q <= diff_d;
      end
      SFric: ox_q <= fr_d;
      default: ;
    endcase
    if (issue) begin
      out_data_q <= {tick_after, blue, green, red, pos_y, pos_x};
    end
  end

  // ---------------------------------------------------------------- assertions
  a_fric_after_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SFric |-> $past(state_q) == SBy && hit_q.on_floor)
    else $error("friction step without floor contact");

  a_step_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !s_axis_tuser |=> state_q == SVel)
    else $error("step item did not start the velocity step");

  a_issue_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> m_axis_tvalid && state_q == SIdle)
    else $error("issued result not presented");

  a_tick_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && !is_load_q |=> ticks_q == $past(ticks_q) + 32'd1)
    else $error("tick count not advanced by a step");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for verlet_particle_box_step
// Streams load and step items into the block and checks every result, field
// by field, against a cycle-free model of the particle kept in this bench.
// Register settings change between phases over the config port and are read
// back. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vpbs_pkg::*;

  localparam int     QOne      = 1 << 20;
  localparam longint CenterQ   = 64'sd524288000;
  localparam longint ColorDivQ = 64'sd5242880;
  localparam int     Phases    = 6;
  localparam int     PerPhase  = 110;

  // Result fields, lowest bits last so the struct maps onto m_axis_tdata
  typedef struct packed {
    logic [31:0] ticks;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } particle_out_t;

  typedef struct {
    bit            is_load;
    logic [31:0]   x, y, px, py, t;
    bit            typed;
    particle_out_t want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // tdata: load_x, load_y, load_prev_x, load_prev_y, load_ticks
  logic [InDataW-1:0]  s_axis_tdata;
  // tuser: req_type
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // tdata: pos_x, pos_y, color_red, color_green, color_blue, tick_count
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // Particle and register copies kept by the bench
  int          cur_x, cur_y, old_x, old_y;
  int unsigned tick_cnt;
  logic [27:0] cfg_radius;
  logic [15:0] cfg_friction;
  logic [15:0] cfg_bounce;
  logic [19:0] cfg_gravity;
  logic [30:0] cfg_box_w;
  logic [30:0] cfg_box_h;

  particle_out_t awaited[$];
  int            mismatch_cnt = 0;
  bit            snd_burst = 1'b0;
  bit            rcv_burst = 1'b0;

  const logic [2:0] all_regs[6] = '{RegRadius, RegFriction, RegBounce, RegGravity,
                                    RegBoxWidth, RegBoxHeight};

  verlet_particle_box_step u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_cnt < 40) begin
      $display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
    end
    mismatch_cnt++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report(what, got, want);
    end
  endtask

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q1.15 scale, rounded toward minus infinity
  function automatic longint scale_q15(longint v, logic [15:0] f);
    return (v * longint'(f)) >>> 15;
  endfunction

  // Build the result from the current particle state
  function automatic particle_out_t shade_particle(int unsigned tick_prev);
    particle_out_t r;
    longint        dx;
    dx = longint'(cur_x) - CenterQ;
    if (dx < 0) dx = -dx;
    r.pos_x = cur_x;
    r.pos_y = cur_y;
    r.red   = 8'(dx / ColorDivQ);
    r.green = 8'(longint'(cur_y) / ColorDivQ);
    r.blue  = 8'(tick_prev / 32'd50);
    r.ticks = tick_cnt;
    return r;
  endfunction

  // Apply one item to the particle and return the result it should produce
  function automatic particle_out_t advance_particle(logic is_load, logic [InDataW-1:0] d);
    longint      vx, vy, nx, ny, ox, oy, rad, lim_x, lim_y;
    int unsigned tick_prev;
    if (is_load) begin
      cur_x    = d[31:0];
      cur_y    = d[63:32];
      old_x    = d[95:64];
      old_y    = d[127:96];
      tick_cnt = d[159:128];
      return shade_particle(tick_cnt);
    end
    vx = clamp_s32(longint'(cur_x) - longint'(old_x));
    vy = clamp_s32(longint'(cur_y) - longint'(old_y));
    ox = cur_x;
    oy = cur_y;
    vy = clamp_s32(vy + longint'(cfg_gravity));
    nx = clamp_s32(longint'(cur_x) + vx);
    ny = clamp_s32(longint'(cur_y) + vy);
    rad   = longint'(cfg_radius);
    lim_x = longint'(cfg_box_w) - 2 * rad;
    lim_y = longint'(cfg_box_h) - 2 * rad;
    // Left wall first, right wall overrides when the walls cross
    if (nx < rad) begin
      nx = rad;
      ox = clamp_s32(nx + scale_q15(vx, cfg_bounce));
    end
    if (nx > lim_x) begin
      nx = lim_x;
      ox = clamp_s32(nx + scale_q15(vx, cfg_bounce));
    end
    if (ny < rad) begin
      ny = rad;
      oy = clamp_s32(ny + scale_q15(vy, cfg_bounce));
    end
    // Floor contact also applies friction to the horizontal velocity
    if (ny > lim_y) begin
      ny = lim_y;
      oy = clamp_s32(ny + scale_q15(vy, cfg_bounce));
      ox = clamp_s32(nx - scale_q15(nx - ox, cfg_friction));
    end
    cur_x     = int'(nx);
    cur_y     = int'(ny);
    old_x     = int'(ox);
    old_y     = int'(oy);
    tick_prev = tick_cnt;
    tick_cnt  = tick_cnt + 1;
    return shade_particle(tick_prev);
  endfunction

  function automatic logic [31:0] reg_value(logic [2:0] idx);
    case (idx)
      RegRadius:    return {4'd0, cfg_radius};
      RegFriction:  return {16'd0, cfg_friction};
      RegBounce:    return {16'd0, cfg_bounce};
      RegGravity:   return {12'd0, cfg_gravity};
      RegBoxWidth:  return {1'b0, cfg_box_w};
      RegBoxHeight: return {1'b0, cfg_box_h};
      default:      return '0;
    endcase
  endfunction

  // Config port transfers: setup phase, access phase, then idle with psel low
  task automatic apb_write(logic [2:0] idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apb_read_check(logic [2:0] idx);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    check_field($sformatf("register %0d readback", idx), got, reg_value(idx));
  endtask

  task automatic set_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      RegRadius:    cfg_radius   = v[27:0];
      RegFriction:  cfg_friction = v[15:0];
      RegBounce:    cfg_bounce   = v[15:0];
      RegGravity:   cfg_gravity  = v[19:0];
      RegBoxWidth:  cfg_box_w    = v[30:0];
      RegBoxHeight: cfg_box_h    = v[30:0];
      default: ;
    endcase
    apb_write(idx, v);
    apb_read_check(idx);
  endtask

  task automatic apply_setting(logic [31:0] rad, logic [31:0] fric, logic [31:0] bnc,
                               logic [31:0] grav, logic [31:0] bw, logic [31:0] bh);
    set_reg(RegRadius, rad);
    set_reg(RegFriction, fric);
    set_reg(RegBounce, bnc);
    set_reg(RegGravity, grav);
    set_reg(RegBoxWidth, bw);
    set_reg(RegBoxHeight, bh);
  endtask

  // Offer one item after a random gap and record what it should produce
  task automatic send_item(logic is_load, logic [InDataW-1:0] d, bit typed,
                           particle_out_t typed_want);
    int            gap;
    particle_out_t p;
    if ($urandom_range(0, 15) == 0) snd_burst = !snd_burst;
    gap = snd_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= is_load;
    do @(posedge clk_i); while (!s_axis_tready);
    p = advance_particle(is_load, d);
    awaited.push_back(typed ? typed_want : p);
    @(negedge clk_i);
  endtask

  // Hold the input side until every awaited result is out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Output side: stall a random number of cycles before each item
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) rcv_burst = !rcv_burst;
      stall = rcv_burst ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Compare each delivered item with the oldest awaited result
  always @(posedge clk_i) begin
    particle_out_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (awaited.size() == 0) begin
        report("item with nothing awaited, tick_count", got.ticks, '0);
      end else begin
        want = awaited.pop_front();
        check_field("pos_x", got.pos_x, want.pos_x);
        check_field("pos_y", got.pos_y, want.pos_y);
        check_field("color_red", {24'd0, got.red}, {24'd0, want.red});
        check_field("color_green", {24'd0, got.green}, {24'd0, want.green});
        check_field("color_blue", {24'd0, got.blue}, {24'd0, want.blue});
        check_field("tick_count", got.ticks, want.ticks);
      end
    end
  end

  initial begin
    dir_row_t           dir_tab[$];
    logic [InDataW-1:0] item;
    logic [31:0]        lx, ly, lt;
    int                 vx, vy, run, sent;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    cfg_radius    = RadiusRst;
    cfg_friction  = FrictionRst;
    cfg_bounce    = BounceRst;
    cfg_gravity   = GravityRst;
    cfg_box_w     = BoxWidthRst;
    cfg_box_h     = BoxHeightRst;
    cur_x = 0;
    cur_y = 0;
    old_x = 0;
    old_y = 0;
    tick_cnt = 0;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Registers come out of reset at their defaults
    foreach (all_regs[i]) apb_read_check(all_regs[i]);

    // Directed items at the default setting
    // step from reset: both top-left walls clamp the particle
    dir_tab.push_back('{1'b0, '0, '0, '0, '0, '0, 1'b1,
      '{ticks: 32'd1, blue: 8'd0, green: 8'd2, red: 8'd98,
        pos_y: 10 * QOne, pos_x: 10 * QOne}});
    // load at the horizontal center, at rest
    dir_tab.push_back('{1'b1, 500 * QOne, '0, 500 * QOne, '0, '0, 1'b1,
      '{ticks: 32'd0, blue: 8'd0, green: 8'd0, red: 8'd0, pos_y: '0, pos_x: 500 * QOne}});
    dir_tab.push_back('{1'b0, '0, '0, '0, '0, '0, 1'b0, '0});
    // load extremes: largest velocities and tick count about to wrap
    dir_tab.push_back('{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
      32'hFFFF_FFFF, 1'b1,
      '{ticks: 32'hFFFF_FFFF, blue: 8'd81, green: 8'd103, red: 8'd53,
        pos_y: 32'h8000_0000, pos_x: 32'h7FFF_FFFF}});
    dir_tab.push_back('{1'b0, '0, '0, '0, '0, '0, 1'b0, '0});
    dir_tab.push_back('{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
      32'd49, 1'b1,
      '{ticks: 32'd49, blue: 8'd0, green: 8'd153, red: 8'd253,
        pos_y: 32'h7FFF_FFFF, pos_x: 32'h8000_0000}});
    dir_tab.push_back('{1'b0, '0, '0, '0, '0, '0, 1'b0, '0});
    dir_tab.push_back('{1'b0, '0, '0, '0, '0, '0, 1'b0, '0});
    // falling onto the floor with sideways motion, friction applies
    dir_tab.push_back('{1'b1, 250 * QOne, 489 * QOne, 248 * QOne, 487 * QOne, 32'd100, 1'b1,
      '{ticks: 32'd100, blue: 8'd2, green: 8'd97, red: 8'd50,
        pos_y: 489 * QOne, pos_x: 250 * QOne}});
    repeat (3) dir_tab.push_back('{1'b0, '0, '0, '0, '0, '0, 1'b0, '0});
    // right wall
    dir_tab.push_back('{1'b1, 489 * QOne, 200 * QOne, 485 * QOne, 200 * QOne, 32'd1000,
      1'b0, '0});
    dir_tab.push_back('{1'b0, '0, '0, '0, '0, '0, 1'b0, '0});
    // left wall
    dir_tab.push_back('{1'b1, 11 * QOne, 100 * QOne, 15 * QOne, 101 * QOne, 32'd7, 1'b0, '0});
    dir_tab.push_back('{1'b0, '0, '0, '0, '0, '0, 1'b0, '0});
    // bottom-left corner
    dir_tab.push_back('{1'b1, 5 * QOne, 495 * QOne, 8 * QOne, 490 * QOne, 32'd3, 1'b0, '0});
    repeat (2) dir_tab.push_back('{1'b0, '0, '0, '0, '0, '0, 1'b0, '0});
    // back to the origin
    dir_tab.push_back('{1'b1, '0, '0, '0, '0, '0, 1'b1,
      '{ticks: 32'd0, blue: 8'd0, green: 8'd0, red: 8'd100, pos_y: '0, pos_x: '0}});
    repeat (2) dir_tab.push_back('{1'b0, '0, '0, '0, '0, '0, 1'b0, '0});

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].is_load,
                {dir_tab[i].t, dir_tab[i].py, dir_tab[i].px, dir_tab[i].y, dir_tab[i].x},
                dir_tab[i].typed, dir_tab[i].want);
    end

    // Random phases, each under its own register setting
    for (int phase = 0; phase < Phases; phase++) begin
      wait_drained();
      case (phase)
        0: apply_setting(RadiusRst, FrictionRst, BounceRst, GravityRst,
                         BoxWidthRst, BoxHeightRst);
        1: apply_setting('1, '1, '1, '1, '1, '1);
        2: apply_setting('0, '0, '0, '0, '0, '0);
        // radius so large that the walls cross
        3: apply_setting($urandom_range(28'hFFF_FFFF, 180 * QOne), 32'd32768, 32'd0,
                         $urandom_range(20'hF_FFFF, 0), 500 * QOne, 500 * QOne);
        4: apply_setting($urandom_range(20 * QOne, 0), $urandom_range(32768, 0),
                         $urandom_range(32768, 0), $urandom_range(20'hF_FFFF, 0),
                         $urandom_range(1000 * QOne, 100 * QOne),
                         $urandom_range(1000 * QOne, 100 * QOne));
        default: apply_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      endcase

      sent = 0;
      while (sent < PerPhase) begin
        // Load a particle, mostly inside the box with a modest velocity
        if ($urandom_range(0, 7) == 0) begin
          item = {$urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
          lx = $urandom_range(cfg_box_w, 0);
          ly = $urandom_range(cfg_box_h, 0);
          vx = int'($urandom_range(8 * QOne, 0)) - 4 * QOne;
          vy = int'($urandom_range(8 * QOne, 0)) - 4 * QOne;
          lt = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(40, 0) : $urandom;
          item = {lt, ly - vy, lx - vx, ly, lx};
        end
        send_item(1'b1, item, 1'b0, '0);
        sent++;
        // Then let it run, payload bits are don't-care on steps
        run = $urandom_range(30, 3);
        repeat (run) begin
          item = {$urandom, $urandom, $urandom, $urandom, $urandom};
          send_item(1'b0, item, 1'b0, '0);
          sent++;
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
